// ----- rtl/dq_pkg.sv -----
// Package for the double-ended queue: sizes, operation and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package dq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int SUM_BITS  = CNT_BITS + 1;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_dq_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2
    } t_dq_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_EMIT
    } t_dq_state;

    typedef struct packed {
        logic capture;   // latch the accepted item
        logic exec;      // update index, count and caches; RAM access
        logic load_rd;   // take RAM read data into the front/back cache
        logic load_out;  // load the result register
    } t_dq_cmd;

    typedef struct packed {
        logic need_read; // pop leaves words behind: new front/back comes from RAM
        logic out_free;  // result register can take a new result this cycle
    } t_dq_stat;

endpackage

// ----- rtl/dq_if.sv -----
// Valid/ready channel interfaces for the queue's input items and results.
// Depends on dq_pkg.
interface dq_in_if
    import dq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_dq_op               operation;
    logic [WORD_BITS-1:0] push_word;

    modport source (output valid, operation, push_word, input ready);
    modport sink   (input valid, operation, push_word, output ready);
endinterface

interface dq_out_if
    import dq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_dq_status           status;
    logic [WORD_BITS-1:0] popped_word;
    logic [CNT_BITS-1:0]  entry_count;
    logic [WORD_BITS-1:0] front_word;
    logic [WORD_BITS-1:0] back_word;
    logic                 is_empty;

    modport source (output valid, status, popped_word, entry_count, front_word, back_word,
                    is_empty, input ready);
    modport sink   (input valid, status, popped_word, entry_count, front_word, back_word,
                    is_empty, output ready);
endinterface

// ----- rtl/double_ended_queue.sv -----
// Bounded double-ended queue of DEPTH words; one result per accepted operation.
// The item is captured in IDLE and executed in EXEC; a pop that leaves words also passes
// RDWAIT, the registered read of the ring RAM that fetches the new front or back word.
// EMIT loads the result register; no new item is taken until then, and output stalls hold EMIT.
// Reset (i_rst_n, synchronous, active low): queue empty, head at zero, no result pending;
// the ring RAM is not cleared, only entries inside the stored range are ever read.
module double_ended_queue
    import dq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_in_if.sink    i_item,
    dq_out_if.source o_result
);

    t_dq_cmd  cmd;
    t_dq_stat stat;
    logic     in_ready;

    // Controller: IDLE -> EXEC -> (RDWAIT) -> EMIT -> IDLE
    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_item.ready = in_ready;

    // Datapath: ring storage, index/count, front/back caches, result register
    dq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_operation (i_item.operation),
        .i_push_word (i_item.push_word),
        .o_result    (o_result)
    );

    // Only one operation in flight: no new transfer right after one was taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input taken while an operation is in flight");

    // Refused operations never report a popped word
    a_refused_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_DONE) |-> (o_result.popped_word == '0))
        else $error("refused operation reports a popped word");

    // Count never exceeds the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.entry_count <= CNT_BITS'(DEPTH)))
        else $error("entry count beyond capacity");

    // Empty queue shows zero front and back words
    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.is_empty) |->
            (o_result.front_word == '0 && o_result.back_word == '0))
        else $error("empty queue shows nonzero front or back");

endmodule

// ----- rtl/dq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/dq_ctrl.sv -----
// Controller state machine for the queue: sequences capture, execute,
// RAM read and result load. Depends on dq_pkg.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dq_stat i_stat,
    output t_dq_cmd  o_cmd
);

    t_dq_state r_state;
    t_dq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_stat.need_read ? S_RDWAIT : S_EMIT;
            end
            S_RDWAIT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_RDWAIT: begin
                o_cmd.load_rd = 1'b1;
            end
            S_EMIT: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/dq_dp.sv -----
// Datapath for the queue: ring RAM, head index, count, front/back word
// caches and the result register. Depends on dq_pkg, dq_if, dq_ram.
module dq_dp
    import dq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dq_cmd              i_cmd,
    output t_dq_stat             o_stat,
    input  t_dq_op               i_operation,
    input  logic [WORD_BITS-1:0] i_push_word,
    dq_out_if.source             o_result
);

    // head + offset, wrapped into the ring
    function automatic logic [IDX_BITS-1:0] ring_add(input logic [IDX_BITS-1:0] base,
                                                     input logic [CNT_BITS-1:0] off);
        logic [SUM_BITS-1:0] sum;
        sum = SUM_BITS'(base) + SUM_BITS'(off);
        if (sum >= SUM_BITS'(DEPTH)) begin
            sum = sum - SUM_BITS'(DEPTH);
        end
        return sum[IDX_BITS-1:0];
    endfunction

    // latched item
    t_dq_op               r_op;
    logic [WORD_BITS-1:0] r_word;

    // queue state
    logic [IDX_BITS-1:0]  r_head,  n_head;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic [WORD_BITS-1:0] r_front, n_front;
    logic [WORD_BITS-1:0] r_back,  n_back;
    t_dq_status           r_status, n_status;
    logic [WORD_BITS-1:0] r_popped, n_popped;
    logic                 r_rd_front, n_rd_front;

    // result register
    logic                 r_out_valid;
    t_dq_status           r_res_status;
    logic [WORD_BITS-1:0] r_res_popped;
    logic [CNT_BITS-1:0]  r_res_count;
    logic [WORD_BITS-1:0] r_res_front;
    logic [WORD_BITS-1:0] r_res_back;

    logic                 is_full;
    logic                 is_empty;
    logic [IDX_BITS-1:0]  head_dec;
    logic [IDX_BITS-1:0]  head_inc;
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_addr;
    logic                 rd_en;
    logic [IDX_BITS-1:0]  rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 need_read;
    logic                 out_free;

    assign is_full  = (r_count == CNT_BITS'(DEPTH));
    assign is_empty = (r_count == '0);
    assign head_dec = (r_head == '0) ? IDX_BITS'(DEPTH - 1) : r_head - IDX_BITS'(1);
    assign head_inc = ring_add(r_head, CNT_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_word <= i_push_word;
        end
    end

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_front    = r_front;
        n_back     = r_back;
        n_status   = r_status;
        n_popped   = r_popped;
        n_rd_front = r_rd_front;
        wr_en      = 1'b0;
        wr_addr    = r_head;
        rd_en      = 1'b0;
        rd_addr    = head_inc;
        need_read  = 1'b0;

        if (i_cmd.exec) begin
            n_status = ST_DONE;
            n_popped = '0;
            unique case (r_op)
                OP_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_head  = head_dec;
                        wr_en   = 1'b1;
                        wr_addr = head_dec;
                        n_front = r_word;
                        if (is_empty) begin
                            n_back = r_word;
                        end
                        n_count = r_count + CNT_BITS'(1);
                    end
                end
                OP_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = ring_add(r_head, r_count);
                        n_back  = r_word;
                        if (is_empty) begin
                            n_front = r_word;
                        end
                        n_count = r_count + CNT_BITS'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped   = r_front;
                        n_head     = head_inc;
                        n_count    = r_count - CNT_BITS'(1);
                        n_rd_front = 1'b1;
                        rd_addr    = head_inc;
                        if (r_count > CNT_BITS'(1)) begin
                            rd_en     = 1'b1;
                            need_read = 1'b1;
                        end
                    end
                end
                OP_POP_BACK: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped   = r_back;
                        n_count    = r_count - CNT_BITS'(1);
                        n_rd_front = 1'b0;
                        rd_addr    = ring_add(r_head, r_count - CNT_BITS'(2));
                        if (r_count > CNT_BITS'(1)) begin
                            rd_en     = 1'b1;
                            need_read = 1'b1;
                        end
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end

        if (i_cmd.load_rd) begin
            if (r_rd_front) begin
                n_front = rd_data;
            end else begin
                n_back = rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
        r_front    <= n_front;
        r_back     <= n_back;
        r_status   <= n_status;
        r_popped   <= n_popped;
        r_rd_front <= n_rd_front;
    end

    dq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_word),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result register
    assign out_free = !r_out_valid || o_result.ready;
    assign o_stat   = '{need_read: need_read, out_free: out_free};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_res_status <= r_status;
            r_res_popped <= r_popped;
            r_res_count  <= r_count;
            r_res_front  <= is_empty ? '0 : r_front;
            r_res_back   <= is_empty ? '0 : r_back;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_res_status;
    assign o_result.popped_word = r_res_popped;
    assign o_result.entry_count = r_res_count;
    assign o_result.front_word  = r_res_front;
    assign o_result.back_word   = r_res_back;
    assign o_result.is_empty    = (r_res_count == '0);

endmodule

// ----- tb/sv/double_ended_queue_test.sv -----
// Self-checking testbench for double_ended_queue: directed corner cases, then biased random
// push/pop bursts under random idling on both channels, checked against an in-bench predictor.
// Depends on dq_pkg, dq_if (dq_in_if, dq_out_if) and the double_ended_queue RTL.
module double_ended_queue_test
    import dq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS    = 1450;
    localparam int HOLD_CYCLES    = 400;   // long output hold-off, fills the block
    localparam int DRAIN_CYCLES   = 20;    // tail after the last result
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        t_dq_op               op;
        logic [WORD_BITS-1:0] word;
    } t_deque_item;

    typedef struct packed {
        t_dq_status           status;
        logic [WORD_BITS-1:0] popped_word;
        logic [CNT_BITS-1:0]  entry_count;
        logic [WORD_BITS-1:0] front_word;
        logic [WORD_BITS-1:0] back_word;
        logic                 is_empty;
    } t_deque_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dq_in_if  item_ch();
    dq_out_if result_ch();

    double_ended_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: shadow ring with its own head and count. Entries outside
    // the stored range are never read, so the ring needs no clearing.
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] shadow_ring [DEPTH];
    logic [IDX_BITS-1:0]  shadow_head  = '0;
    logic [CNT_BITS-1:0]  shadow_count = '0;

    t_deque_item   pending_items[$];     // stimulus not yet offered
    t_deque_result expected_results[$];  // predicted, not yet transferred

    int unsigned pushes_done    = 0;
    int unsigned pops_done      = 0;
    int unsigned full_refusals  = 0;
    int unsigned empty_refusals = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned holdoffs_done  = 0;

    function automatic logic [IDX_BITS-1:0] ring_slot(int unsigned offset);
        return IDX_BITS'((int'(shadow_head) + offset) % DEPTH);
    endfunction

    // Apply one operation to the shadow state and queue the result it gives.
    function automatic void predict_deque_step(t_deque_item it);
        t_deque_result res;
        res        = '0;
        res.status = ST_DONE;
        case (it.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (shadow_count == CNT_BITS'(DEPTH)) begin
                    res.status = ST_FULL;
                    full_refusals++;
                end else if (it.op == OP_PUSH_FRONT) begin
                    shadow_head              = ring_slot(DEPTH - 1);
                    shadow_ring[shadow_head] = it.word;
                    shadow_count++;
                    pushes_done++;
                end else begin
                    shadow_ring[ring_slot(shadow_count)] = it.word;
                    shadow_count++;
                    pushes_done++;
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                    empty_refusals++;
                end else if (it.op == OP_POP_FRONT) begin
                    res.popped_word = shadow_ring[shadow_head];
                    shadow_head     = ring_slot(1);
                    shadow_count--;
                    pops_done++;
                end else begin
                    res.popped_word = shadow_ring[ring_slot(shadow_count - 1)];
                    shadow_count--;
                    pops_done++;
                end
            end
        endcase
        res.entry_count = shadow_count;
        res.is_empty    = (shadow_count == 0);
        if (shadow_count != 0) begin
            res.front_word = shadow_ring[shadow_head];
            res.back_word  = shadow_ring[ring_slot(shadow_count - 1)];
        end
        expected_results.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending items with a random gap before each one.
    // The gap mode flips now and then so there are runs with no idling.
    // ------------------------------------------------------------------
    t_deque_item offered_item;
    int unsigned send_gap    = 0;
    bit          send_steady = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            send_gap = $urandom_range(0, 7);
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                predict_deque_step(offered_item);
            end
            // Bus is free for a new item after this edge
            if (!item_ch.valid || item_ch.ready) begin
                if (send_gap != 0 || pending_items.size() == 0) begin
                    if (send_gap != 0) begin
                        send_gap--;
                    end
                    item_ch.valid <= 1'b0;
                end else begin
                    offered_item = pending_items.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.operation <= offered_item.op;
                    item_ch.push_word <= offered_item.word;
                    if ($urandom_range(0, 39) == 0) begin
                        send_steady = !send_steady;
                    end
                    send_gap = send_steady ? 0 : $urandom_range(0, 7);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output hold-off: twice in the run, ready is held low for a long
    // stretch while the driver keeps offering, so the block backs up
    // and stalls its input.
    // ------------------------------------------------------------------
    logic        result_hold = 1'b0;
    int unsigned in_transfers = 0;
    int unsigned hold_left    = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_transfers = 0;
            hold_left    = 0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                in_transfers++;
            end
            if (hold_left != 0) begin
                hold_left--;
            end else if (item_ch.valid && item_ch.ready &&
                         (in_transfers == 300 || in_transfers == 1000)) begin
                hold_left = HOLD_CYCLES;
                holdoffs_done++;
            end
        end
        result_hold <= (hold_left != 0);
    end

    // ------------------------------------------------------------------
    // Monitor: takes results with a random stall, compares each against
    // the oldest prediction.
    // ------------------------------------------------------------------
    t_deque_result seen_result;
    t_deque_result wanted_result;
    int unsigned   recv_wait   = 0;
    bit            recv_steady = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                seen_result.status      = result_ch.status;
                seen_result.popped_word = result_ch.popped_word;
                seen_result.entry_count = result_ch.entry_count;
                seen_result.front_word  = result_ch.front_word;
                seen_result.back_word   = result_ch.back_word;
                seen_result.is_empty    = result_ch.is_empty;
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("[%0t] result %0d arrived with nothing expected",
                                 $realtime, results_seen);
                    end
                end else begin
                    wanted_result = expected_results.pop_front();
                    if (seen_result !== wanted_result) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d mismatch", $realtime, results_seen);
                            $display("  expected: st=%0d pop=%h cnt=%0d front=%h back=%h emp=%b",
                                     wanted_result.status, wanted_result.popped_word,
                                     wanted_result.entry_count, wanted_result.front_word,
                                     wanted_result.back_word, wanted_result.is_empty);
                            $display("  actual:   st=%0d pop=%h cnt=%0d front=%h back=%h emp=%b",
                                     seen_result.status, seen_result.popped_word,
                                     seen_result.entry_count, seen_result.front_word,
                                     seen_result.back_word, seen_result.is_empty);
                        end
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    recv_steady = !recv_steady;
                end
                recv_wait = recv_steady ? 0 : $urandom_range(0, 7);
            end
            if (result_hold) begin
                result_ch.ready <= 1'b0;
            end else if (recv_wait != 0) begin
                recv_wait--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any cycle with a transfer on either side clears the count.
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[%0t] no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    function automatic void queue_item(t_dq_op op, logic [WORD_BITS-1:0] word);
        t_deque_item it;
        it.op   = op;
        it.word = word;
        pending_items.push_back(it);
    endfunction

    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return WORD_BITS'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned burst_len;
        int unsigned push_pct;
        bit          do_push;
        bit          at_front;
        t_dq_op      op;

        // Known values on every input from time zero
        item_ch.valid     = 1'b0;
        item_ch.operation = OP_PUSH_FRONT;
        item_ch.push_word = '0;
        result_ch.ready   = 1'b0;

        // Directed: pops on empty (word must be ignored), a two-entry
        // round trip at both ends, head wrapping below zero, then fill
        // to full with alternating patterns and try both pushes on full.
        queue_item(OP_POP_FRONT, '1);
        queue_item(OP_POP_BACK, 32'h8000_0001);
        queue_item(OP_PUSH_FRONT, '0);
        queue_item(OP_PUSH_BACK, '1);
        queue_item(OP_POP_FRONT, 32'h1234_5678);
        queue_item(OP_POP_BACK, '1);
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 4)
                0:       queue_item(OP_PUSH_FRONT, 32'hAAAA_AAAA ^ i);
                1:       queue_item(OP_PUSH_BACK, 32'h5555_5555 ^ i);
                2:       queue_item(OP_PUSH_FRONT, (i % 8 == 2) ? '1 : 32'h8000_0000);
                default: queue_item(OP_PUSH_BACK, (i % 8 == 3) ? '0 : 32'h0000_0001);
            endcase
        end
        queue_item(OP_PUSH_FRONT, 32'hDEAD_0000);
        queue_item(OP_PUSH_BACK, '1);

        // Random: bursts biased toward filling, draining or mixed traffic,
        // so the store swings between empty and full many times.
        while (pending_items.size() < TOTAL_ITEMS) begin
            burst_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            repeat (burst_len) begin
                do_push  = ($urandom_range(0, 99) < push_pct);
                at_front = $urandom_range(0, 1);
                if (do_push) begin
                    op = at_front ? OP_PUSH_FRONT : OP_PUSH_BACK;
                end else begin
                    op = at_front ? OP_POP_FRONT : OP_POP_BACK;
                end
                queue_item(op, pick_word());
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $display("%0d predicted results never arrived", expected_results.size());
        end
        $display("Covered %0d pushes and %0d pops done, %0d pushes refused full,",
                 pushes_done, pops_done, full_refusals);
        $display("%0d pops refused empty, %0d results checked, %0d output hold-offs, %0d mismatches",
                 empty_refusals, results_seen, holdoffs_done, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
